>>> rtl/sexpr_token_scanner_core_assert.svh
// Assertion macros for the s-expression token scanner.
// Expect clk and arst_n in the scope of the file that includes this header.
`ifndef SEXPR_TOKEN_SCANNER_CORE_ASSERT_SVH
`define SEXPR_TOKEN_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sts_pkg.sv
// Shared types, codes and helpers of the s-expression token scanner.
// No dependencies; the front end, queue, back end, top and bench use it.
package sts_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int POS_BITS_DEF    = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int RES_SLOTS       = 3;

	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DIV    = 8'h2F;
	localparam logic [7:0] CH_MUL    = 8'h2A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_QUOTE  = 8'h27;

	typedef enum logic [3:0] {
		KIND_LPAREN  = 4'd0,
		KIND_RPAREN  = 4'd1,
		KIND_DIV     = 4'd2,
		KIND_MUL     = 4'd3,
		KIND_MINUS   = 4'd4,
		KIND_PLUS    = 4'd5,
		KIND_QUOTE   = 4'd6,
		KIND_WORD    = 4'd7,
		KIND_UNKNOWN = 4'd8,
		KIND_END     = 4'd9
	} kind_t;

	// Classified byte, passed from the front end to the back end.
	typedef struct packed {
		logic  fin;
		logic  is_letter;
		logic  is_space;
		kind_t tok_kind;
	} item_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start_pos;
		logic [15:0] token_length;
		logic [6:0]  nest_depth;
		logic [15:0] expr_id;
		logic [15:0] token_total;
		logic        overflow;
		logic        last;
	} res_t;

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == CNT_MAX) ? v : v + 16'd1;
	endfunction

endpackage

>>> rtl/sts_if.sv
// Valid/ready channel interfaces of the s-expression token scanner.
// Source byte channel and token result channel; no dependencies.
interface sts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_text;

	modport source(output valid, char_byte, end_of_text, input ready);
	modport sink(input valid, char_byte, end_of_text, output ready);
endinterface

interface sts_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [15:0] start_pos;
	logic [15:0] token_length;
	logic [6:0]  nest_depth;
	logic [15:0] expr_id;
	logic [15:0] token_total;
	logic        overflow;
	logic        last;

	modport source(output valid, kind, start_pos, token_length, nest_depth, expr_id,
		token_total, overflow, last, input ready);
	modport sink(input valid, kind, start_pos, token_length, nest_depth, expr_id,
		token_total, overflow, last, output ready);
endinterface

>>> rtl/sts_front.sv
// Front end: accepts source bytes and classifies them into queue items.
// Depends on sts_pkg and sts_in_if.
module sts_front (
	sts_in_if.sink          in_ch,
	input  sts_pkg::q_stat_t q_stat,
	output logic            push,
	output sts_pkg::item_t  push_item
);

	logic [7:0] c;

	assign c         = in_ch.char_byte;
	assign in_ch.ready = !q_stat.full;
	assign push      = in_ch.valid && !q_stat.full;

	always_comb begin
		push_item.fin       = in_ch.end_of_text;
		push_item.is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
		push_item.is_space  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
		unique case (c)
			sts_pkg::CH_LPAREN: push_item.tok_kind = sts_pkg::KIND_LPAREN;
			sts_pkg::CH_RPAREN: push_item.tok_kind = sts_pkg::KIND_RPAREN;
			sts_pkg::CH_DIV:    push_item.tok_kind = sts_pkg::KIND_DIV;
			sts_pkg::CH_MUL:    push_item.tok_kind = sts_pkg::KIND_MUL;
			sts_pkg::CH_MINUS:  push_item.tok_kind = sts_pkg::KIND_MINUS;
			sts_pkg::CH_PLUS:   push_item.tok_kind = sts_pkg::KIND_PLUS;
			sts_pkg::CH_QUOTE:  push_item.tok_kind = sts_pkg::KIND_QUOTE;
			default:            push_item.tok_kind = sts_pkg::KIND_UNKNOWN;
		endcase
	end

endmodule

>>> rtl/sts_fifo.sv
// Short queue of classified items between the front end and the back end.
// Depends on sts_pkg.
module sts_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sts_pkg::item_t   push_item,
	input  logic             pop,
	output sts_pkg::q_stat_t q_stat,
	output sts_pkg::item_t   head_item
);

	localparam int D     = sts_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (D > 1) ? $clog2(D) : 1;
	localparam int CNT_W = $clog2(D + 1);

	sts_pkg::item_t    store_q [D];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = (count_q == CNT_W'(D));
	assign q_stat.valid = (count_q != '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && q_stat.valid;
	assign head_item    = store_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(D - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) store_q[wr_ptr_q] <= push_item;
	end

endmodule

>>> rtl/sts_back.sv
// Back end: carries out one queued item per cycle unless held by pending results, keeps
// the id stack and scan state, and drains up to three results per item. Depends on sts_pkg, sts_out_if.
module sts_back #(
	parameter int STACK_DEPTH = sts_pkg::STACK_DEPTH_DEF,
	parameter int POS_BITS    = sts_pkg::POS_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sts_pkg::q_stat_t q_stat,
	input  sts_pkg::item_t   head_item,
	output logic             pop,
	sts_out_if.source        out_ch
);

	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam logic [POS_BITS-1:0] POS_MAX  = '1;
	localparam logic [LVL_W-1:0]    LVL_FULL = LVL_W'(STACK_DEPTH);

	// Stack entries below the top; the top itself lives in top_q.
	logic [15:0]         stk_mem [STACK_DEPTH];

	logic [LVL_W-1:0]    level_q;
	logic [15:0]         top_q;
	logic [15:0]         below_q;
	logic [15:0]         next_id_q;
	logic [POS_BITS-1:0] pos_q;
	logic                word_active_q;
	logic [15:0]         word_start_q;
	logic [15:0]         word_len_q;
	logic [15:0]         word_id_q;
	logic [15:0]         count_q;
	logic                ov_q;

	sts_pkg::res_t       res_q [sts_pkg::RES_SLOTS];
	logic [1:0]          remain_q;
	logic [1:0]          rd_q;

	sts_pkg::item_t      it;
	logic                take;
	logic                tok;
	logic                emit_pend;
	logic                fin_word;
	logic                is_push;
	logic                is_rparen;
	logic                do_push;
	logic                do_pop;
	logic [15:0]         cur_top;
	logic [LVL_W-1:0]    level_n;
	logic [15:0]         top_n;
	logic [15:0]         top_id_n;
	logic                w_active_n;
	logic [15:0]         w_start_n;
	logic [15:0]         w_len_n;
	logic [15:0]         w_id_n;
	logic [15:0]         cnt1;
	logic [15:0]         cnt2;
	logic [POS_BITS-1:0] pos_n;
	logic                ov_n;
	logic [15:0]         next_id_n;
	sts_pkg::res_t       r_pend;
	sts_pkg::res_t       r_tok;
	sts_pkg::res_t       r_fin_word;
	sts_pkg::res_t       r_end;
	sts_pkg::res_t       res_n [sts_pkg::RES_SLOTS];
	logic [1:0]          n;

	assign it   = head_item;
	// Take the next item once the result buffer is empty or empties in this cycle.
	assign take = q_stat.valid && ((remain_q == 2'd0) || (remain_q == 2'd1 && out_ch.ready));
	assign pop  = take;

	always_comb begin
		cur_top   = (level_q == '0) ? 16'd0 : top_q;
		tok       = !it.is_letter && !it.is_space;
		emit_pend = !it.is_letter && word_active_q;
		fin_word  = it.fin && it.is_letter;
		is_push   = tok && (it.tok_kind == sts_pkg::KIND_LPAREN);
		is_rparen = tok && (it.tok_kind == sts_pkg::KIND_RPAREN);
		do_push   = is_push && (level_q != LVL_FULL);
		do_pop    = is_rparen && (level_q != '0);

		level_n = level_q;
		top_n   = top_q;
		if (do_push) begin
			level_n = level_q + LVL_W'(1);
			top_n   = next_id_q;
		end else if (do_pop) begin
			level_n = level_q - LVL_W'(1);
			top_n   = below_q;
		end
		top_id_n  = (level_n == '0) ? 16'd0 : top_n;
		ov_n      = ov_q | (is_push && !do_push);
		next_id_n = is_push ? ((next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1)
			: next_id_q;
		pos_n     = (pos_q == POS_MAX) ? pos_q : pos_q + POS_BITS'(1);

		w_active_n = word_active_q;
		w_start_n  = word_start_q;
		w_len_n    = word_len_q;
		w_id_n     = word_id_q;
		if (it.is_letter) begin
			if (!word_active_q) begin
				w_active_n = 1'b1;
				w_start_n  = 16'(pos_q);
				w_len_n    = 16'd1;
				w_id_n     = cur_top;
			end else begin
				w_len_n = sts_pkg::sat_inc16(word_len_q);
			end
		end else begin
			w_active_n = 1'b0;
		end

		cnt1 = emit_pend ? sts_pkg::sat_inc16(count_q) : count_q;
		cnt2 = (tok || fin_word) ? sts_pkg::sat_inc16(cnt1) : cnt1;

		r_pend = '{kind: sts_pkg::KIND_WORD, start_pos: word_start_q,
			token_length: word_len_q, nest_depth: 7'(level_q), expr_id: word_id_q,
			token_total: 16'd0, overflow: ov_q, last: 1'b0};
		// Close paren reports the depth after its pop.
		r_tok = '{kind: it.tok_kind, start_pos: 16'(pos_q), token_length: 16'd1,
			nest_depth: is_rparen ? 7'(level_n) : 7'(level_q), expr_id: cur_top,
			token_total: 16'd0, overflow: ov_q, last: 1'b0};
		r_fin_word = '{kind: sts_pkg::KIND_WORD, start_pos: w_start_n,
			token_length: w_len_n, nest_depth: 7'(level_n), expr_id: w_id_n,
			token_total: 16'd0, overflow: ov_q, last: 1'b0};
		r_end = '{kind: sts_pkg::KIND_END, start_pos: 16'(pos_n), token_length: 16'd0,
			nest_depth: 7'(level_n), expr_id: top_id_n, token_total: cnt2,
			overflow: ov_n, last: 1'b1};

		// Pack results in order: pending word, byte token, final word, end.
		n = 2'd0;
		for (int i = 0; i < sts_pkg::RES_SLOTS; i++) res_n[i] = r_end;
		if (emit_pend) begin
			res_n[n] = r_pend;
			n        = n + 2'd1;
		end
		if (tok) begin
			res_n[n] = r_tok;
			n        = n + 2'd1;
		end
		if (fin_word) begin
			res_n[n] = r_fin_word;
			n        = n + 2'd1;
		end
		if (it.fin) begin
			res_n[n] = r_end;
			n        = n + 2'd1;
		end
		if (n != 2'd0) res_n[n - 2'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= '0;
			next_id_q     <= 16'd1;
			pos_q         <= '0;
			word_active_q <= 1'b0;
			word_start_q  <= 16'd0;
			word_len_q    <= 16'd0;
			word_id_q     <= 16'd0;
			count_q       <= 16'd0;
			ov_q          <= 1'b0;
			remain_q      <= 2'd0;
			rd_q          <= 2'd0;
		end else begin
			if (take) begin
				remain_q <= n;
				rd_q     <= 2'd0;
				if (it.fin) begin
					// End of text: start the next text from reset values.
					level_q       <= '0;
					next_id_q     <= 16'd1;
					pos_q         <= '0;
					word_active_q <= 1'b0;
					word_start_q  <= 16'd0;
					word_len_q    <= 16'd0;
					word_id_q     <= 16'd0;
					count_q       <= 16'd0;
					ov_q          <= 1'b0;
				end else begin
					level_q       <= level_n;
					next_id_q     <= next_id_n;
					pos_q         <= pos_n;
					word_active_q <= w_active_n;
					word_start_q  <= w_start_n;
					word_len_q    <= w_len_n;
					word_id_q     <= w_id_n;
					count_q       <= cnt2;
					ov_q          <= ov_n;
				end
			end else if (out_ch.valid && out_ch.ready) begin
				remain_q <= remain_q - 2'd1;
				rd_q     <= rd_q + 2'd1;
			end
		end
	end

	// Stack top, the entry below it, the stack memory and the result buffer.
	always_ff @(posedge clk) begin
		if (take) begin
			top_q <= top_n;
			if (do_push) begin
				if (level_q != '0) stk_mem[IDX_W'(level_q - LVL_W'(1))] <= top_q;
				below_q <= top_q;
			end else if (do_pop && level_q >= LVL_W'(3)) begin
				below_q <= stk_mem[IDX_W'(level_q - LVL_W'(3))];
			end
			res_q <= res_n;
		end
	end

	assign out_ch.valid        = (remain_q != 2'd0);
	assign out_ch.kind         = res_q[rd_q].kind;
	assign out_ch.start_pos    = res_q[rd_q].start_pos;
	assign out_ch.token_length = res_q[rd_q].token_length;
	assign out_ch.nest_depth   = res_q[rd_q].nest_depth;
	assign out_ch.expr_id      = res_q[rd_q].expr_id;
	assign out_ch.token_total  = res_q[rd_q].token_total;
	assign out_ch.overflow     = res_q[rd_q].overflow;
	assign out_ch.last         = res_q[rd_q].last;

endmodule

>>> rtl/sexpr_token_scanner_core.sv
// A byte is held in the item queue, then its results are registered in the back end's result buffer.
// Throughput: one byte per cycle while no item gives more than one result and the port is ready;
// an item with more results holds the result port until all are taken (an item gives 0 to 3).
// The two-entry item queue lets input and output stall independently.
// Reset: asynchronous arst_n clears queue, scan state and result buffer;
// the id stack memory is not cleared.
`include "sexpr_token_scanner_core_assert.svh"

module sexpr_token_scanner_core #(
	parameter int STACK_DEPTH = sts_pkg::STACK_DEPTH_DEF,
	parameter int POS_BITS    = sts_pkg::POS_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sts_in_if.sink    in_ch,
	sts_out_if.source out_ch
);

	sts_pkg::q_stat_t q_stat;
	sts_pkg::item_t   push_item;
	sts_pkg::item_t   head_item;
	logic             push;
	logic             pop;

	sts_front u_front (
		.in_ch     (in_ch),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	sts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_stat    (q_stat),
		.head_item (head_item)
	);

	sts_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.POS_BITS    (POS_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_item (head_item),
		.pop       (pop),
		.out_ch    (out_ch)
	);

	`STS_ASSERT_IMP(a_end_is_last, out_ch.valid && out_ch.kind == sts_pkg::KIND_END, out_ch.last, "end result not marked last")
	`STS_ASSERT_IMP(a_total_only_end, out_ch.valid && out_ch.kind != sts_pkg::KIND_END, out_ch.token_total == 16'd0, "token total on non-end result")
	`STS_ASSERT_NXT(a_full_blocks, q_stat.full && !pop, !in_ch.ready, "input ready while queue stays full")
	`STS_ASSERT_IMP(a_pop_has_item, pop, q_stat.valid, "back end pops an empty queue")

endmodule

>>> test/tb.sv
// Self-checking bench for sexpr_token_scanner_core: drives source bytes, predicts every token.
// Depends on sts_pkg (rtl/sts_pkg.sv) and the channel interfaces in rtl/sts_if.sv.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sts_pkg::*;

	localparam int STACK_LIMIT = STACK_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 100000;
	localparam res_t NO_TOKEN = '0;

	typedef struct {
		logic [7:0] ch;
		bit         fin;
		bit         typed;
		res_t       want;
	} probe_row_t;

	logic clk;
	logic arst_n;

	sts_in_if  in_ch();
	sts_out_if out_ch();

	sexpr_token_scanner_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// lexer state as seen by the predictor
	logic [15:0] id_stack_m [STACK_LIMIT];
	int          open_level;
	logic [15:0] fresh_id;
	logic [15:0] scan_pos;
	bit          in_word;
	logic [15:0] word_at;
	logic [15:0] word_bytes;
	logic [15:0] word_owner;
	logic [15:0] tok_count;
	bit          nest_overflow;

	res_t fresh_tokens[$];
	res_t pending_tokens[$];

	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int rx_hold_req = 0;
	int cycle_count;

	probe_row_t probe_rows [27];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic res_t tok(kind_t k, int s, int l, int d, int id, int tot);
		res_t t;
		t.kind = k;
		t.start_pos = s[15:0];
		t.token_length = l[15:0];
		t.nest_depth = d[6:0];
		t.expr_id = id[15:0];
		t.token_total = tot[15:0];
		t.overflow = 1'b0;
		t.last = 1'b1;
		return t;
	endfunction

	function automatic logic [15:0] enclosing_id();
		return (open_level == 0) ? 16'd0 : id_stack_m[open_level - 1];
	endfunction

	function automatic void clear_scan_state();
		open_level = 0;
		fresh_id = 16'd1;
		scan_pos = 16'd0;
		in_word = 1'b0;
		word_at = 16'd0;
		word_bytes = 16'd0;
		word_owner = 16'd0;
		tok_count = 16'd0;
		nest_overflow = 1'b0;
	endfunction

	function automatic void note_token(kind_t k, logic [15:0] s, logic [15:0] l, int d,
		logic [15:0] id, logic [15:0] tot);
		res_t t;
		t = tok(k, s, l, d, id, tot);
		t.overflow = nest_overflow;
		t.last = 1'b0;
		fresh_tokens.push_back(t);
		if (k != KIND_END && tok_count != CNT_MAX)
			tok_count++;
	endfunction

	function automatic void flush_word();
		note_token(KIND_WORD, word_at, word_bytes, open_level, word_owner, 16'd0);
		in_word = 1'b0;
	endfunction

	// Advance the lexer state by one byte; leave its tokens in fresh_tokens.
	function automatic void lex_byte(logic [7:0] c, bit fin);
		bit          letter;
		bit          space;
		logic [15:0] here;
		logic [15:0] closing;
		kind_t       k;
		letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
		space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
		here = scan_pos;
		fresh_tokens.delete();

		if (letter) begin
			if (!in_word) begin
				in_word = 1'b1;
				word_at = here;
				word_bytes = 16'd1;
				word_owner = enclosing_id();
			end else if (word_bytes != CNT_MAX) begin
				word_bytes++;
			end
		end else if (in_word) begin
			flush_word();
		end

		if (!letter && !space) begin
			if (c == CH_LPAREN) begin
				note_token(KIND_LPAREN, here, 16'd1, open_level, enclosing_id(), 16'd0);
				// a full stack drops the push but still burns the id
				if (open_level < STACK_LIMIT) begin
					id_stack_m[open_level] = fresh_id;
					open_level++;
				end else begin
					nest_overflow = 1'b1;
				end
				fresh_id = (fresh_id == CNT_MAX) ? 16'd1 : fresh_id + 16'd1;
			end else if (c == CH_RPAREN) begin
				closing = enclosing_id();
				if (open_level > 0)
					open_level--;
				note_token(KIND_RPAREN, here, 16'd1, open_level, closing, 16'd0);
			end else begin
				case (c)
					CH_DIV:   k = KIND_DIV;
					CH_MUL:   k = KIND_MUL;
					CH_MINUS: k = KIND_MINUS;
					CH_PLUS:  k = KIND_PLUS;
					CH_QUOTE: k = KIND_QUOTE;
					default:  k = KIND_UNKNOWN;
				endcase
				note_token(k, here, 16'd1, open_level, enclosing_id(), 16'd0);
			end
		end

		if (scan_pos != CNT_MAX)
			scan_pos++;

		if (fin) begin
			if (in_word)
				flush_word();
			note_token(KIND_END, scan_pos, 16'd0, open_level, enclosing_id(), tok_count);
			clear_scan_state();
		end

		if (fresh_tokens.size() > 0)
			fresh_tokens[$].last = 1'b1;
	endfunction

	task automatic offer_byte(logic [7:0] c, bit fin, bit typed, res_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_byte <= c;
		in_ch.end_of_text <= fin;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		lex_byte(c, fin);
		if (typed) begin
			pending_tokens.push_back(want);
		end else begin
			foreach (fresh_tokens[j])
				pending_tokens.push_back(fresh_tokens[j]);
		end
	endtask

	// Hold the sender until every expected token is out, then let the pipe settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void check_field(string name, int unsigned exp, int unsigned got);
		if (exp != got) begin
			$error("%s: expected %0d, got %0d", name, exp, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_tokens.size() == 0) begin
				$error("token with none expected: kind %0d at %0d", out_ch.kind, out_ch.start_pos);
				fail_count++;
			end else begin
				want = pending_tokens.pop_front();
				check_field("kind", want.kind, out_ch.kind);
				check_field("start_pos", want.start_pos, out_ch.start_pos);
				check_field("token_length", want.token_length, out_ch.token_length);
				check_field("nest_depth", want.nest_depth, out_ch.nest_depth);
				check_field("expr_id", want.expr_id, out_ch.expr_id);
				check_field("token_total", want.token_total, out_ch.token_total);
				check_field("overflow", want.overflow, out_ch.overflow);
				check_field("last", want.last, out_ch.last);
			end
		end
	end

	// Result side: random stalls, plus a long hold-off counted down here.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int          i;
		int          ph;
		int          roll;
		int          text_left;
		bit          fin;
		bit          in_run;
		logic [7:0]  c;
		logic [7:0]  op_chars [5];

		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.char_byte <= 8'h00;
		in_ch.end_of_text <= 1'b0;
		clear_scan_state();
		op_chars = '{CH_DIV, CH_MUL, CH_MINUS, CH_PLUS, CH_QUOTE};

		probe_rows = '{
			'{CH_LPAREN, 1'b0, 1'b1, tok(KIND_LPAREN, 0, 1, 0, 0, 0)},
			'{8'h61,     1'b0, 1'b0, NO_TOKEN},
			'{8'h5A,     1'b0, 1'b0, NO_TOKEN},
			'{8'h20,     1'b0, 1'b1, tok(KIND_WORD, 1, 2, 1, 1, 0)},
			'{CH_PLUS,   1'b0, 1'b1, tok(KIND_PLUS, 4, 1, 1, 1, 0)},
			'{CH_MINUS,  1'b0, 1'b1, tok(KIND_MINUS, 5, 1, 1, 1, 0)},
			'{CH_MUL,    1'b0, 1'b1, tok(KIND_MUL, 6, 1, 1, 1, 0)},
			'{CH_DIV,    1'b0, 1'b1, tok(KIND_DIV, 7, 1, 1, 1, 0)},
			'{CH_QUOTE,  1'b0, 1'b1, tok(KIND_QUOTE, 8, 1, 1, 1, 0)},
			'{8'h7A,     1'b0, 1'b0, NO_TOKEN},
			'{CH_RPAREN, 1'b0, 1'b0, NO_TOKEN},
			'{CH_RPAREN, 1'b0, 1'b1, tok(KIND_RPAREN, 11, 1, 0, 0, 0)},
			'{8'h00,     1'b0, 1'b1, tok(KIND_UNKNOWN, 12, 1, 0, 0, 0)},
			'{8'hFF,     1'b0, 1'b1, tok(KIND_UNKNOWN, 13, 1, 0, 0, 0)},
			'{8'h09,     1'b0, 1'b0, NO_TOKEN},
			'{8'h0D,     1'b0, 1'b0, NO_TOKEN},
			'{8'h0A,     1'b0, 1'b0, NO_TOKEN},
			'{8'h41,     1'b0, 1'b0, NO_TOKEN},
			'{CH_LPAREN, 1'b1, 1'b0, NO_TOKEN},
			'{8'h40,     1'b0, 1'b1, tok(KIND_UNKNOWN, 0, 1, 0, 0, 0)},
			'{8'h5B,     1'b0, 1'b1, tok(KIND_UNKNOWN, 1, 1, 0, 0, 0)},
			'{8'h60,     1'b0, 1'b1, tok(KIND_UNKNOWN, 2, 1, 0, 0, 0)},
			'{8'h7B,     1'b0, 1'b1, tok(KIND_UNKNOWN, 3, 1, 0, 0, 0)},
			'{8'h08,     1'b0, 1'b1, tok(KIND_UNKNOWN, 4, 1, 0, 0, 0)},
			'{8'h0E,     1'b0, 1'b1, tok(KIND_UNKNOWN, 5, 1, 0, 0, 0)},
			'{8'h62,     1'b1, 1'b0, NO_TOKEN},
			'{8'h20,     1'b1, 1'b1, tok(KIND_END, 1, 0, 0, 0, 0)}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_rows[r])
			offer_byte(probe_rows[r].ch, probe_rows[r].fin, probe_rows[r].typed,
				probe_rows[r].want);
		drain();

		// Random texts: mostly words, parens and operators, some raw noise.
		in_run = 1'b0;
		text_left = $urandom_range(3, 40);
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  rx_hold_req = 100; end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			for (i = 0; i < 40; i++) begin
				roll = $urandom_range(99);
				if ((in_run && roll < 60) || (!in_run && roll < 18)) begin
					c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
					in_run = 1'b1;
				end else begin
					in_run = 1'b0;
					roll = $urandom_range(99);
					if (roll < 20) begin
						roll = $urandom_range(0, 5);
						c = (roll == 5) ? 8'h20 : 8'(9 + roll);
					end else if (roll < 42) begin
						c = CH_LPAREN;
					end else if (roll < 62) begin
						c = CH_RPAREN;
					end else if (roll < 82) begin
						c = op_chars[$urandom_range(0, 4)];
					end else begin
						c = 8'($urandom_range(0, 255));
					end
				end
				text_left--;
				fin = (text_left == 0);
				if (fin)
					text_left = $urandom_range(1, 40);
				offer_byte(c, fin, 1'b0, NO_TOKEN);
			end
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		offer_byte(8'h20, 1'b1, 1'b0, NO_TOKEN);
		drain();

		// Deep text: fill the stack, overflow it, then unwind past the top level.
		for (i = 0; i < STACK_LIMIT + 2; i++)
			offer_byte(CH_LPAREN, 1'b0, 1'b0, NO_TOKEN);
		for (i = 0; i < STACK_LIMIT + 6; i++)
			offer_byte(CH_RPAREN, 1'b0, 1'b0, NO_TOKEN);
		offer_byte(8'h71, 1'b1, 1'b0, NO_TOKEN);
		drain();

		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_tokens.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sexpr_token_scanner_core.f
+incdir+rtl
rtl/sts_pkg.sv
rtl/sts_if.sv
rtl/sts_front.sv
rtl/sts_fifo.sv
rtl/sts_back.sv
rtl/sexpr_token_scanner_core.sv
test/tb.sv
